[src/pet_pkg.sv]
// Shared types and constants for the postfix expression type checker.
package pet_pkg;

  localparam int unsigned StackDepthDef = 16;

  typedef enum logic [3:0] {
    TOK_INT     = 4'd0,
    TOK_BOOL    = 4'd1,
    TOK_OTHER   = 4'd2,
    TOK_ARITH   = 4'd3,
    TOK_REL     = 4'd4,
    TOK_LOGIC   = 4'd5,
    TOK_UN_ARITH = 4'd6,
    TOK_UN_LOGIC = 4'd7,
    TOK_UNCLASSED = 4'd8
  } tok_class_e;

  typedef enum logic [1:0] {
    TY_INT     = 2'd0,
    TY_BOOL    = 2'd1,
    TY_OTHER   = 2'd2,
    TY_UNKNOWN = 2'd3
  } ty_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISSING   = 3'd1,
    ERR_TYPES     = 3'd2,
    ERR_MALFORMED = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_e;

endpackage

[src/postfix_expression_type_checker.sv]
// Postfix expression type checker: type stack with cached top two entries.
// A result is registered and appears in the cycle after its last token is accepted.
// Throughput: one token per cycle; the top two stack entries sit in registers
// and the third is prefetched from the stack RAM through its registered read port.
// Input stalls only while a result is held and the output is stalled.
// Reset (async, active low) empties the stack, clears the error and the output valid.
module postfix_expression_type_checker #(
  parameter int unsigned STACK_DEPTH = pet_pkg::StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] token_class_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] result_type_o,
  output logic [2:0] error_code_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  logic [CW-1:0]    count_q, count_d, count_n;
  pet_pkg::err_e    err_q, err_d, err_n;
  pet_pkg::ty_e     top_q, top_d, next_q, next_d, third_q;
  logic             out_valid_q, out_valid_d;
  pet_pkg::ty_e     res_ty_q, res_ty_d;
  pet_pkg::err_e    res_err_q, res_err_d;

  logic [1:0]       stack_mem [STACK_DEPTH];
  logic             push_en, mem_we;
  pet_pkg::ty_e     push_ty;
  logic [CW-1:0]    wa_full, ra_full;
  logic             accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    count_n = count_q;
    err_n   = err_q;
    top_d   = top_q;
    next_d  = next_q;
    push_en = 1'b0;
    push_ty = pet_pkg::TY_INT;
    if (accept && err_q == pet_pkg::ERR_NONE) begin
      case (pet_pkg::tok_class_e'(token_class_i))
        pet_pkg::TOK_INT, pet_pkg::TOK_BOOL, pet_pkg::TOK_OTHER: begin
          if (count_q == DepthC) begin
            err_n = pet_pkg::ERR_OVERFLOW;
          end else begin
            push_en = 1'b1;
            push_ty = pet_pkg::ty_e'(token_class_i[1:0]);
            top_d   = push_ty;
            next_d  = top_q;
            count_n = count_q + CW'(1);
          end
        end
        pet_pkg::TOK_UN_ARITH, pet_pkg::TOK_UN_LOGIC: begin
          if (count_q == '0) begin
            err_n = pet_pkg::ERR_MISSING;
          end else if (top_q != ((token_class_i[0]) ? pet_pkg::TY_BOOL : pet_pkg::TY_INT)) begin
            err_n = pet_pkg::ERR_TYPES;
          end
        end
        default: begin
          // binary operators; unknown codes behave as unclassed
          if (count_q < CW'(2)) begin
            err_n = pet_pkg::ERR_MISSING;
          end else if ((token_class_i == pet_pkg::TOK_ARITH ||
                        token_class_i == pet_pkg::TOK_REL) &&
                       top_q == pet_pkg::TY_INT && next_q == pet_pkg::TY_INT) begin
            top_d   = (token_class_i == pet_pkg::TOK_ARITH) ? pet_pkg::TY_INT
                                                              : pet_pkg::TY_BOOL;
            next_d  = third_q;
            count_n = count_q - CW'(1);
          end else if (token_class_i == pet_pkg::TOK_LOGIC &&
                       top_q == pet_pkg::TY_BOOL && next_q == pet_pkg::TY_BOOL) begin
            top_d   = pet_pkg::TY_BOOL;
            next_d  = third_q;
            count_n = count_q - CW'(1);
          end else begin
            err_n = pet_pkg::ERR_TYPES;
          end
        end
      endcase
    end

    count_d     = count_n;
    err_d       = err_n;
    out_valid_d = out_valid_q && out_stall_i;
    res_ty_d    = res_ty_q;
    res_err_d   = res_err_q;
    if (accept && last_i) begin
      out_valid_d = 1'b1;
      res_ty_d    = pet_pkg::TY_UNKNOWN;
      res_err_d   = err_n;
      if (err_n == pet_pkg::ERR_NONE) begin
        if (count_n == CW'(1)) begin
          res_ty_d = top_d;
        end else begin
          res_err_d = pet_pkg::ERR_MALFORMED;
        end
      end
      count_d = '0;
      err_d   = pet_pkg::ERR_NONE;
    end
  end

  // entries below the top two live in RAM; a push spills the old second entry
  assign mem_we  = push_en && (count_q >= CW'(2));
  assign wa_full = count_q - CW'(2);
  assign ra_full = count_n - CW'(3);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wa_full[AW-1:0]] <= next_q;
    end
    // spilled entry becomes third directly, bypassing the RAM
    if (push_en) begin
      third_q <= next_q;
    end else begin
      third_q <= pet_pkg::ty_e'(stack_mem[ra_full[AW-1:0]]);
    end
    top_q     <= top_d;
    next_q    <= next_d;
    res_ty_q  <= res_ty_d;
    res_err_q <= res_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= pet_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_type_o = res_ty_q;
  assign error_code_o  = res_err_q;

endmodule

[src/pet_checker.sv]
// Port-level checks for the postfix expression type checker, bound to the top level.
module pet_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] result_type_o,
  input logic [2:0] error_code_o
);

  // an error result always carries the unknown type, and only then
  a_err_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_code_o != pet_pkg::ERR_NONE) ==
                     (result_type_o == pet_pkg::TY_UNKNOWN)))
    else $error("result type and error code disagree");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o <= pet_pkg::ERR_OVERFLOW))
    else $error("error code out of range");

  // a new result only follows an accepted last item
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !($past(out_valid_o) && $past(out_stall_i))) |->
      $past(in_valid_i && !in_stall_o && last_i))
    else $error("result without a last item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_type_o) && $stable(error_code_o)))
    else $error("stalled result changed");

  // input is held back only by a waiting result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind postfix_expression_type_checker pet_checker u_pet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_type_o (result_type_o),
  .error_code_o  (error_code_o)
);
